// ===== hw/rtl/mvnb_pkg.sv =====
// ----------------------------------------------------------------------------
// mvnb_pkg
// Shared types and constants of the vertex normal builder.
// ----------------------------------------------------------------------------
package mvnb_pkg;

	localparam int VERTEX_CAPACITY_DEF  = 4096;
	localparam int COORD_BITS_DEF       = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	localparam int IDX_W  = 12;
	localparam int FLD_W  = 16;
	localparam int SUM_W  = 24;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TRI  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [0:0] REG_SMOOTH_MODE = 1'd0;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [IDX_W-1:0]        vert_a;
		logic [IDX_W-1:0]        vert_b;
		logic [IDX_W-1:0]        vert_c;
		logic signed [FLD_W-1:0] coord_x;
		logic signed [FLD_W-1:0] coord_y;
		logic signed [FLD_W-1:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [FLD_W-1:0] normal_x;
		logic signed [FLD_W-1:0] normal_y;
		logic signed [FLD_W-1:0] normal_z;
		logic                    normal_valid;
	} out_item_t;

	// request/response between the sequencer and the normalizer
	typedef struct packed {
		logic start;
	} norm_req_t;

	typedef struct packed {
		logic done;
		logic nonzero;
	} norm_rsp_t;

endpackage

// ===== hw/rtl/mesh_vertex_normal_builder_core.sv =====
// ----------------------------------------------------------------------------
// mesh_vertex_normal_builder_core
// Per-vertex normals of a triangle mesh in fixed point.
// ----------------------------------------------------------------------------
// A load item is written into the stores as it is taken. A triangle with
// valid corners, or a read of a touched entry, runs one shared normalizer:
// squaring, 36 root steps and 3 x 16 divide steps; a triangle with a nonzero
// normal then updates its three corners through the single sum memory port.
// After reset a clearing pass over every entry wipes the stores before the
// first item is taken. One item is in work at a time; the result register
// lets the next item in while a read result waits.
module mesh_vertex_normal_builder_core #(
	parameter int VERTEX_CAPACITY  = mvnb_pkg::VERTEX_CAPACITY_DEF,
	parameter int COORD_BITS       = mvnb_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = mvnb_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mvnb_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mvnb_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import mvnb_pkg::*;

	localparam int AW  = (VERTEX_CAPACITY > 1) ? $clog2(VERTEX_CAPACITY) : 1;
	localparam int CB  = COORD_BITS;
	localparam int VW  = 2 * (CB + 1) + 2;   // cross product component
	localparam int NW  = NORMAL_FRAC_BITS + 2;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD0   = 4'd2;
	localparam logic [3:0] S_RD1   = 4'd3;
	localparam logic [3:0] S_RD2   = 4'd4;
	localparam logic [3:0] S_RDW   = 4'd5;
	localparam logic [3:0] S_CROSS = 4'd6;
	localparam logic [3:0] S_NORM  = 4'd7;
	localparam logic [3:0] S_UPRD  = 4'd8;
	localparam logic [3:0] S_UPWR  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]      state_q;
	logic [AW:0]     clr_q;
	logic            smooth_q;
	in_item_t        item_q;
	logic [1:0]      corner_q;

	logic [3*CB-1:0] vmem [VERTEX_CAPACITY];
	logic [3*SUM_W:0] smem [VERTEX_CAPACITY];   // {touched, x, y, z}
	logic [3*CB-1:0] vrd_q;
	logic [3*SUM_W:0] srd_q;
	logic [AW-1:0]   raddr;
	logic [CB-1:0]   p_q [3][3];
	logic signed [VW-1:0] cr_q [3];

	norm_req_t       nreq;
	norm_rsp_t       nrsp;
	logic signed [NW-1:0] nx, ny, nz;
	logic signed [VW-1:0] vx, vy, vz;
	logic            is_read_q, valid_q;
	out_item_t       out_q;
	logic            out_full_q;

	logic            in_acc, cfg_wr;
	logic [AW-1:0]   ia, ib, ic, cur_idx;
	logic            a_ok, b_ok, c_ok;
	logic signed [CB+1:0] du [3], dv [3];
	logic signed [SUM_W+1:0] add_x, add_y, add_z;

	function automatic logic signed [SUM_W-1:0] sat(input logic signed [SUM_W+1:0] t);
		if (t > (SUM_W+2)'((1 << (SUM_W-1)) - 1))
			return SUM_W'((1 << (SUM_W-1)) - 1);
		else if (t < -(SUM_W+2)'(1 << (SUM_W-1)))
			return SUM_W'(-(1 << (SUM_W-1)));
		return t[SUM_W-1:0];
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == {REG_SMOOTH_MODE, 1'b0} || 1'b0)
	                && paddr[1:0] == 2'd0;
	assign prdata = {31'd0, smooth_q};

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = out_full_q;
	assign out_data  = out_q;

	assign ia = item_q.vert_a[AW-1:0];
	assign ib = item_q.vert_b[AW-1:0];
	assign ic = item_q.vert_c[AW-1:0];
	assign a_ok = 32'(item_q.vert_a) < VERTEX_CAPACITY;
	assign b_ok = 32'(item_q.vert_b) < VERTEX_CAPACITY;
	assign c_ok = 32'(item_q.vert_c) < VERTEX_CAPACITY;
	assign cur_idx = (corner_q == 2'd0) ? ia : (corner_q == 2'd1) ? ib : ic;

	// a read keeps its own entry on the port so the normalizer picks up its sums
	always_comb begin
		raddr = cur_idx;
		if (state_q == S_RD0) raddr = ia;
		if (state_q == S_RD1 && !is_read_q) raddr = ib;
		if (state_q == S_RD2) raddr = ic;
	end

	// coordinate differences: u = p2 - p0, v = p1 - p0
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			du[k] = (CB+2)'($signed(p_q[2][k])) - (CB+2)'($signed(p_q[0][k]));
			dv[k] = (CB+2)'($signed(p_q[1][k])) - (CB+2)'($signed(p_q[0][k]));
		end
	end

	assign vx = is_read_q ? VW'($signed(srd_q[3*SUM_W-1:2*SUM_W])) : cr_q[0];
	assign vy = is_read_q ? VW'($signed(srd_q[2*SUM_W-1:SUM_W]))   : cr_q[1];
	assign vz = is_read_q ? VW'($signed(srd_q[SUM_W-1:0]))         : cr_q[2];

	mvnb_normalize #(.VW(VW), .FRAC(NORMAL_FRAC_BITS)) u_norm (
		.clk, .arst_n, .req(nreq), .vx, .vy, .vz, .rsp(nrsp), .nx, .ny, .nz
	);

	assign add_x = (smooth_q ? (SUM_W+2)'($signed(srd_q[3*SUM_W-1:2*SUM_W])) : '0)
	               + (SUM_W+2)'(nx);
	assign add_y = (smooth_q ? (SUM_W+2)'($signed(srd_q[2*SUM_W-1:SUM_W])) : '0)
	               + (SUM_W+2)'(ny);
	assign add_z = (smooth_q ? (SUM_W+2)'($signed(srd_q[SUM_W-1:0])) : '0)
	               + (SUM_W+2)'(nz);

	always_ff @(posedge clk) begin
		vrd_q <= vmem[raddr];
		srd_q <= smem[raddr];
		if (state_q == S_CLR) begin
			vmem[clr_q[AW-1:0]] <= '0;
			smem[clr_q[AW-1:0]] <= '0;
		end
		if (in_acc && in_data.cmd == CMD_LOAD && 32'(in_data.vert_a) < VERTEX_CAPACITY) begin
			vmem[in_data.vert_a[AW-1:0]] <= {in_data.coord_x[CB-1:0],
			                                  in_data.coord_y[CB-1:0],
			                                  in_data.coord_z[CB-1:0]};
			smem[in_data.vert_a[AW-1:0]] <= '0;
		end
		if (state_q == S_UPWR)
			smem[cur_idx] <= {1'b1, sat(add_x), sat(add_y), sat(add_z)};
		if (in_acc)
			item_q <= in_data;
		if (state_q == S_RD1) {p_q[0][0], p_q[0][1], p_q[0][2]} <= vrd_q;
		if (state_q == S_RD2) {p_q[1][0], p_q[1][1], p_q[1][2]} <= vrd_q;
		if (state_q == S_RDW) {p_q[2][0], p_q[2][1], p_q[2][2]} <= vrd_q;
		if (state_q == S_CROSS) begin
			cr_q[0] <= VW'(du[1] * dv[2]) - VW'(du[2] * dv[1]);
			cr_q[1] <= VW'(du[2] * dv[0]) - VW'(du[0] * dv[2]);
			cr_q[2] <= VW'(du[0] * dv[1]) - VW'(du[1] * dv[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			smooth_q   <= 1'b1;
			out_full_q <= 1'b0;
			corner_q   <= '0;
			is_read_q  <= 1'b0;
			valid_q    <= 1'b0;
			nreq.start <= 1'b0;
		end else begin
			nreq.start <= (state_q == S_CROSS) ||
			              (state_q == S_RD1 && is_read_q && a_ok && srd_q[3*SUM_W]);
			if (cfg_wr)
				smooth_q <= pwdata[0];
			if (out_full_q && !out_stall && state_q != S_OUT)
				out_full_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(VERTEX_CAPACITY - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (in_acc) begin
					corner_q <= '0;
					priority case (in_data.cmd)
						CMD_TRI:  state_q <= S_RD0;
						CMD_READ: state_q <= S_RD0;
						default:  state_q <= S_IDLE;
					endcase
					is_read_q <= (in_data.cmd == CMD_READ);
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					if (is_read_q) begin
						if (a_ok && srd_q[3*SUM_W]) begin
							state_q <= S_NORM;
						end else begin
							valid_q <= 1'b0;
							state_q <= S_OUT;
						end
					end else if (!(a_ok && b_ok && c_ok)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD2;
					end
				end
				S_RD2: state_q <= S_RDW;
				S_RDW: state_q <= S_CROSS;
				S_CROSS: state_q <= S_NORM;
				S_NORM: if (nrsp.done) begin
					if (is_read_q) begin
						valid_q <= nrsp.nonzero;
						state_q <= S_OUT;
					end else if (nrsp.nonzero) begin
						state_q <= S_UPRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_UPRD: state_q <= S_UPWR;
				S_UPWR: begin
					if (corner_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						corner_q <= corner_q + 2'd1;
						state_q  <= S_UPRD;
					end
				end
				S_OUT: if (!out_full_q || !out_stall) begin
					out_full_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_full_q || !out_stall)) begin
			out_q.normal_x     <= valid_q ? FLD_W'(nx) : '0;
			out_q.normal_y     <= valid_q ? FLD_W'(ny) : '0;
			out_q.normal_z     <= valid_q ? FLD_W'(nz) : '0;
			out_q.normal_valid <= valid_q;
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM) |-> in_stall) else $error("item taken while busy");
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(is_read_q)) else $error("result without read");
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !out_valid) else $error("result during clearing");

endmodule

// ===== hw/rtl/mvnb_normalize.sv =====
// ----------------------------------------------------------------------------
// mvnb_normalize
// Iterative normalizer: sum of squares, bit-serial integer root, then a
// restoring divide for each of the three components, one bit per cycle.
// ----------------------------------------------------------------------------
module mvnb_normalize #(
	parameter int VW    = 35,
	parameter int FRAC  = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mvnb_pkg::norm_req_t        req,
	input  logic signed [VW-1:0]       vx,
	input  logic signed [VW-1:0]       vy,
	input  logic signed [VW-1:0]       vz,
	output mvnb_pkg::norm_rsp_t        rsp,
	output logic signed [FRAC+1:0]     nx,
	output logic signed [FRAC+1:0]     ny,
	output logic signed [FRAC+1:0]     nz
);
	import mvnb_pkg::*;

	localparam int MW = VW - 1;          // magnitude width (|v| <= 2^MW)
	localparam int SW = 2 * MW + 2;      // sum of three squares
	localparam int RW = MW + 1;          // root width
	localparam int QW = FRAC + 1;
	localparam int BW = (SW > RW + QW) ? SW : RW + QW;
	localparam int CW = $clog2(BW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          comp_q;
	logic [CW-1:0]       cnt_q;
	logic [MW:0]         mag_q [3];
	logic                neg_q [3];
	logic [SW-1:0]       sum_q;
	logic [SW-1:0]       rem_q;      // root remainder
	logic [RW-1:0]       root_q;
	logic [RW:0]         drem_q;     // divide remainder
	logic [QW-1:0]       quo_q;
	logic [QW:0]         res_q [3];
	logic [2*MW+1:0]     sq;
	logic [SW-1:0]       trial;
	logic [RW:0]         dshift;
	logic [MW:0]         cur_mag;

	function automatic logic [MW:0] absv(input logic signed [VW-1:0] v);
		logic [VW-1:0] t;
		t = v[VW-1] ? -v : v;
		return {1'b0, t[MW-1:0]} | {t[VW-1], {MW{1'b0}}};
	endfunction

	// one multiply per cycle: square of the selected component
	assign cur_mag = mag_q[comp_q];
	assign sq      = cur_mag * cur_mag;

	// bit-serial root: remainder/root method, two bits of the sum a step
	assign trial   = {rem_q[SW-3:0], sum_q[SW-1:SW-2]} -
	                 SW'({root_q, 2'b01});
	assign dshift  = {drem_q[RW-1:0], (cnt_q == CW'(QW) ? cur_mag[MW] : 1'b0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req.start) begin
					state_q <= ST_SQ;
					comp_q  <= '0;
				end
				ST_SQ: if (comp_q == 2'd2) begin
					state_q <= ST_ROOT;
					cnt_q   <= CW'(SW / 2);
				end else begin
					comp_q <= comp_q + 2'd1;
				end
				ST_ROOT: if (cnt_q == CW'(1)) begin
					state_q <= (root_q[RW-2:0] != '0 || !trial[SW-1]) ? ST_DIV : ST_DONE;
					comp_q  <= '0;
					cnt_q   <= CW'(QW);
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
				ST_DIV: if (cnt_q == CW'(0)) begin
					if (comp_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						comp_q <= comp_q + 2'd1;
						cnt_q  <= CW'(QW);
					end
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			mag_q[0] <= absv(vx); neg_q[0] <= vx[VW-1];
			mag_q[1] <= absv(vy); neg_q[1] <= vy[VW-1];
			mag_q[2] <= absv(vz); neg_q[2] <= vz[VW-1];
			sum_q    <= '0;
			rem_q    <= '0;
			root_q   <= '0;
		end
		if (state_q == ST_SQ)
			sum_q <= sum_q + SW'(sq);
		if (state_q == ST_ROOT) begin
			sum_q <= {sum_q[SW-3:0], 2'b00};
			if (!trial[SW-1]) begin
				rem_q  <= trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[SW-3:0], sum_q[SW-1:SW-2]};
				root_q <= {root_q[RW-2:0], 1'b0};
			end
			drem_q <= '0;
			quo_q  <= '0;
		end
		if (state_q == ST_DIV) begin
			// first step loads the magnitude, then one quotient bit a cycle
			if (cnt_q == CW'(QW)) begin
				if ({1'b0, cur_mag} >= {1'b0, root_q}) begin
					drem_q <= (RW+1)'(cur_mag) - (RW+1)'(root_q);
					quo_q  <= QW'(1);
				end else begin
					drem_q <= (RW+1)'(cur_mag);
					quo_q  <= '0;
				end
			end else if (cnt_q != CW'(0)) begin
				if ({dshift[RW-1:0], 1'b0} >> 1 >= (RW+1)'(root_q) && 1'b1) begin
					if (dshift >= (RW+1)'(root_q)) begin
						drem_q <= dshift - (RW+1)'(root_q);
						quo_q  <= {quo_q[QW-2:0], 1'b1};
					end else begin
						drem_q <= dshift;
						quo_q  <= {quo_q[QW-2:0], 1'b0};
					end
				end else if (dshift >= (RW+1)'(root_q)) begin
					drem_q <= dshift - (RW+1)'(root_q);
					quo_q  <= {quo_q[QW-2:0], 1'b1};
				end else begin
					drem_q <= dshift;
					quo_q  <= {quo_q[QW-2:0], 1'b0};
				end
			end else begin
				res_q[comp_q] <= neg_q[comp_q] ? -{1'b0, quo_q} : {1'b0, quo_q};
			end
		end
	end

	assign rsp.done    = (state_q == ST_DONE);
	assign rsp.nonzero = (root_q != '0);
	assign nx = res_q[0];
	assign ny = res_q[1];
	assign nz = res_q[2];

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("normalizer done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (state_q != ST_IDLE) || $past(rsp.done))
		else $error("normalizer left busy without done");
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && rsp.nonzero |-> quo_q <= QW'(1) << FRAC)
		else $error("component above unit");

endmodule

// ===== sim/tb_mesh_vertex_normal_builder_core.sv =====
// ----------------------------------------------------------------------------
// tb_mesh_vertex_normal_builder_core
// Self-checking bench for the vertex normal builder: loads vertices, adds
// triangles in smooth and flat mode, reads normals back and compares each
// read result against an in-bench model of the stores and the normalizer.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_normal_builder_core;
	import mvnb_pkg::*;

	localparam int NVERT = VERTEX_CAPACITY_DEF;
	localparam int FRAC  = NORMAL_FRAC_BITS_DEF;
	localparam int SUM_MAX = 8388607;
	localparam int SUM_MIN = -8388608;
	localparam int SETTLE = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mesh_vertex_normal_builder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// mirror of the block's stores
	logic signed [15:0] vx_mem [NVERT];
	logic signed [15:0] vy_mem [NVERT];
	logic signed [15:0] vz_mem [NVERT];
	int                 sx_mem [NVERT];
	int                 sy_mem [NVERT];
	int                 sz_mem [NVERT];
	bit                 touched_mem [NVERT];
	bit                 smooth;

	out_item_t normals_due[$];
	int  fails;
	int  items_sent;
	int  normals_checked;
	bit  quiet;
	int  stall_left;

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] floor_root(input logic [127:0] s);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 40; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] unit_comp(input longint c, input logic [63:0] len);
		logic [127:0] q;
		q = ({64'd0, magnitude(c)} << FRAC) / {64'd0, len};
		return c < 0 ? -16'(q) : 16'(q);
	endfunction

	// returns 0 when the vector has zero length
	function automatic bit unit_vector(input longint x, input longint y, input longint z,
			output logic signed [15:0] nx, output logic signed [15:0] ny,
			output logic signed [15:0] nz);
		logic [127:0] s;
		logic [63:0] len;
		s = {64'd0, magnitude(x)} * {64'd0, magnitude(x)}
			+ {64'd0, magnitude(y)} * {64'd0, magnitude(y)}
			+ {64'd0, magnitude(z)} * {64'd0, magnitude(z)};
		len = floor_root(s);
		nx = '0; ny = '0; nz = '0;
		if (len == 0)
			return 1'b0;
		nx = unit_comp(x, len);
		ny = unit_comp(y, len);
		nz = unit_comp(z, len);
		return 1'b1;
	endfunction

	function automatic int clamp_sum(input longint t);
		if (t > SUM_MAX) return SUM_MAX;
		if (t < SUM_MIN) return SUM_MIN;
		return int'(t);
	endfunction

	function automatic void fold_face(input int i, input logic signed [15:0] nx,
			input logic signed [15:0] ny, input logic signed [15:0] nz);
		if (smooth) begin
			sx_mem[i] = clamp_sum(longint'(sx_mem[i]) + nx);
			sy_mem[i] = clamp_sum(longint'(sy_mem[i]) + ny);
			sz_mem[i] = clamp_sum(longint'(sz_mem[i]) + nz);
		end else begin
			sx_mem[i] = nx;
			sy_mem[i] = ny;
			sz_mem[i] = nz;
		end
		touched_mem[i] = 1'b1;
	endfunction

	function automatic void update_mesh(input in_item_t it);
		longint ux, uy, uz, wx, wy, wz;
		logic signed [15:0] nx, ny, nz;
		out_item_t r;
		int a, b, c;
		a = it.vert_a; b = it.vert_b; c = it.vert_c;
		case (it.cmd)
			CMD_LOAD: begin
				vx_mem[a] = it.coord_x; vy_mem[a] = it.coord_y; vz_mem[a] = it.coord_z;
				sx_mem[a] = 0; sy_mem[a] = 0; sz_mem[a] = 0;
				touched_mem[a] = 1'b0;
			end
			CMD_TRI: begin
				ux = longint'(vx_mem[c]) - vx_mem[a];
				uy = longint'(vy_mem[c]) - vy_mem[a];
				uz = longint'(vz_mem[c]) - vz_mem[a];
				wx = longint'(vx_mem[b]) - vx_mem[a];
				wy = longint'(vy_mem[b]) - vy_mem[a];
				wz = longint'(vz_mem[b]) - vz_mem[a];
				if (unit_vector(uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx,
						nx, ny, nz)) begin
					fold_face(a, nx, ny, nz);
					fold_face(b, nx, ny, nz);
					fold_face(c, nx, ny, nz);
				end
			end
			CMD_READ: begin
				r = '0;
				if (touched_mem[a] && unit_vector(sx_mem[a], sy_mem[a], sz_mem[a],
						nx, ny, nz)) begin
					r.normal_x = nx; r.normal_y = ny; r.normal_z = nz;
					r.normal_valid = 1'b1;
				end
				normals_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// called at a rising edge; leaves in_valid high unless a gap follows
	task automatic send_item(input in_item_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		update_mesh(it);
		items_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input int a, input int b, input int c,
			input int x, input int y, input int z);
		in_item_t it;
		it.cmd = cmd;
		it.vert_a = a[IDX_W-1:0]; it.vert_b = b[IDX_W-1:0]; it.vert_c = c[IDX_W-1:0];
		it.coord_x = x[15:0]; it.coord_y = y[15:0]; it.coord_z = z[15:0];
		send_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (normals_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input bit mode);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 2'(4 * REG_SMOOTH_MODE);
		pwdata  <= {31'd0, mode};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		smooth = mode;
		@(posedge clk);
	endtask

	// read results
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (normals_due.size() == 0) begin
				$error("normal result with none expected");
				fails++;
			end else begin
				out_item_t e;
				e = normals_due.pop_front();
				normals_checked++;
				if (out_data.normal_x !== e.normal_x) begin
					$error("normal_x expected %0d got %0d", e.normal_x, out_data.normal_x);
					fails++;
				end
				if (out_data.normal_y !== e.normal_y) begin
					$error("normal_y expected %0d got %0d", e.normal_y, out_data.normal_y);
					fails++;
				end
				if (out_data.normal_z !== e.normal_z) begin
					$error("normal_z expected %0d got %0d", e.normal_z, out_data.normal_z);
					fails++;
				end
				if (out_data.normal_valid !== e.normal_valid) begin
					$error("normal_valid expected %0d got %0d", e.normal_valid,
						out_data.normal_valid);
					fails++;
				end
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= ($urandom_range(0, 2) == 0);
			stall_left <= $urandom_range(1, 12);
		end
	end

	task automatic test_untouched_reads();
		send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, NVERT - 1, 0, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_directed_smooth();
		write_mode(1'b1);
		send_cmd(CMD_LOAD, 1, 0, 0, -32768, -32768, -32768);
		send_cmd(CMD_LOAD, 4095, 0, 0, 32767, -32768, 32767);
		send_cmd(CMD_LOAD, 2048, 0, 0, 32767, 32767, -32768);
		send_cmd(CMD_READ, 1, 0, 0, 0, 0, 0);
		send_cmd(CMD_TRI, 1, 4095, 2048, 0, 0, 0);
		send_cmd(CMD_READ, 1, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 4095, 0, 0, 0, 0, 0);
		send_cmd(CMD_LOAD, 3, 0, 0, 0, 100, -7);
		send_cmd(CMD_TRI, 3, 2048, 1, 0, 0, 0);
		send_cmd(CMD_READ, 1, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 2048, 0, 0, 0, 0, 0);
		// collinear corners give no face
		send_cmd(CMD_LOAD, 10, 0, 0, 0, 0, 0);
		send_cmd(CMD_LOAD, 11, 0, 0, 5, 5, 5);
		send_cmd(CMD_LOAD, 12, 0, 0, 10, 10, 10);
		send_cmd(CMD_TRI, 10, 11, 12, 0, 0, 0);
		send_cmd(CMD_READ, 10, 0, 0, 0, 0, 0);
		// unused command
		send_cmd(2'd3, 1, 2, 3, 4, 5, 6);
		// reload clears the sum
		send_cmd(CMD_LOAD, 1, 0, 0, 1, 2, 3);
		send_cmd(CMD_READ, 1, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 3, 0, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_flat_overwrite();
		write_mode(1'b0);
		send_cmd(CMD_LOAD, 20, 0, 0, 0, 0, 0);
		send_cmd(CMD_LOAD, 21, 0, 0, 1000, 0, 0);
		send_cmd(CMD_LOAD, 22, 0, 0, 0, 1000, 0);
		send_cmd(CMD_LOAD, 23, 0, 0, 0, 0, 1000);
		send_cmd(CMD_TRI, 20, 21, 22, 0, 0, 0);
		send_cmd(CMD_TRI, 20, 23, 21, 0, 0, 0);
		send_cmd(CMD_READ, 20, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 22, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 23, 0, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_sum_saturation();
		write_mode(1'b1);
		send_cmd(CMD_LOAD, 30, 0, 0, 0, 0, 0);
		send_cmd(CMD_LOAD, 31, 0, 0, 0, 0, 300);
		send_cmd(CMD_LOAD, 32, 0, 0, 0, 300, 0);
		// each face adds a full unit component, so a little over 512 saturate
		repeat (514) send_cmd(CMD_TRI, 30, 31, 32, 0, 0, 0);
		send_cmd(CMD_READ, 30, 0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 32, 0, 0, 0, 0, 0);
		drain();
	endtask

	function automatic int pick_index();
		return $urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1) : $urandom_range(0, 15);
	endfunction

	task automatic random_phase(input int count);
		int a, b, c;
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) < 7) begin
				a = pick_index(); b = pick_index(); c = pick_index();
				send_cmd(CMD_LOAD, a, 0, 0, $urandom, $urandom, $urandom);
				send_cmd(CMD_LOAD, b, 0, 0, $urandom, $urandom, $urandom);
				send_cmd(CMD_LOAD, c, 0, 0, $urandom, $urandom, $urandom);
				send_cmd(CMD_TRI, a, b, c, 0, 0, 0);
				if ($urandom_range(0, 1) == 0)
					send_cmd(CMD_TRI, pick_index(), b, pick_index(), 0, 0, 0);
				send_cmd(CMD_READ, a, 0, 0, 0, 0, 0);
				send_cmd(CMD_READ, $urandom_range(0, 1) ? b : c, 0, 0, 0, 0, 0);
				n += 7;
			end else begin
				in_item_t it;
				logic [95:0] raw;
				raw = {$urandom, $urandom, $urandom};
				it = raw[$bits(in_item_t)-1:0];
				send_item(it);
				n++;
			end
		end
		drain();
	endtask

	task automatic test_random_mesh();
		write_mode(1'b0);
		random_phase(20);
		write_mode(1'b1);
		random_phase(20);
		write_mode(1'b0);
		random_phase(15);
		quiet = 1'b1;
		write_mode(1'b1);
		random_phase(15);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		fails = 0; items_sent = 0; normals_checked = 0; quiet = 1'b0; stall_left = 0;
		smooth = 1'b1;
		for (int i = 0; i < NVERT; i++) begin
			vx_mem[i] = 0; vy_mem[i] = 0; vz_mem[i] = 0;
			sx_mem[i] = 0; sy_mem[i] = 0; sz_mem[i] = 0;
			touched_mem[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_untouched_reads();
		test_directed_smooth();
		test_flat_overwrite();
		test_sum_saturation();
		test_random_mesh();
		$display("covered %0d items in smooth and flat mode, %0d normals compared",
			items_sent, normals_checked);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mvnb_pkg.sv
hw/rtl/mvnb_normalize.sv
hw/rtl/mesh_vertex_normal_builder_core.sv
sim/tb_mesh_vertex_normal_builder_core.sv
